FILE: sv/grvc_pkg.sv
// Shared constants, types and control structures of the grid ray vertex clamp.
package grvc_pkg;

	localparam int GRID_SIDE  = 64;
	localparam int GRID_W     = $clog2(GRID_SIDE);
	localparam int FRAC_W     = 14;
	localparam int POS_W      = GRID_W + FRAC_W + 2;
	localparam int STEP_MAX   = 4 * GRID_SIDE;
	localparam int STEP_W     = $clog2(STEP_MAX + 2);
	localparam int ROOT_W     = 24;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int DEN_W      = 24;
	localparam int QUO_W      = 16;
	localparam int SQRT_ITERS = ROOT_W;
	localparam int DIV_ITERS  = QUO_W;
	localparam int CNT_W      = $clog2(SQRT_ITERS);
	localparam int CFG_IDX_W  = 2;

	localparam logic signed [POS_W-1:0] POS_START = POS_W'((GRID_SIDE / 2) * (2 ** FRAC_W));
	localparam logic signed [POS_W-1:0] POS_LIMIT = POS_W'(GRID_SIDE * (2 ** FRAC_W));
	localparam logic signed [POS_W-1:0] POS_NEG   = -POS_W'(2 ** FRAC_W);
	localparam logic signed [15:0]      DIR_ONE   = 16'sd16384;

	localparam logic [15:0] CELL_SIZE_RST = 16'd87;
	localparam logic [15:0] CLAMP_RST     = 16'd2560;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP     = 2'd1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef logic [GRID_W-1:0]    idx_t;
	typedef logic [GRID_SIDE-1:0] row_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQX,
		MUL_SQY,
		MUL_DIST,
		MUL_VX,
		MUL_VY
	} mul_sel_t;

	typedef enum logic [2:0] {
		DIV_NONE,
		DIV_DX,
		DIV_DY,
		DIV_SCALE
	} div_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_WR_RD,
		S_WR_WB,
		S_SQX,
		S_SQY,
		S_LSQ,
		S_ROOT_INIT,
		S_ROOT,
		S_DX_INIT,
		S_DX,
		S_DX_ST,
		S_DY_INIT,
		S_DY,
		S_DY_ST,
		S_M_INIT,
		S_M_ADDR,
		S_M_CHK,
		S_D_MUL,
		S_D_CMP,
		S_AX_MUL,
		S_AX_INIT,
		S_AX,
		S_AX_ST,
		S_AY_MUL,
		S_AY_INIT,
		S_AY,
		S_AY_ST,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		logic     lsq_load;
		logic     lsq_add;
		logic     sqrt_init;
		logic     sqrt_step;
		div_sel_t div_init;
		logic     div_step;
		logic     dx_st;
		logic     dy_st;
		logic     dir_zero;
		logic     march_init;
		logic     march_adv;
		logic     found_set;
		logic     dist_st;
		logic     adjx_st;
		logic     adjy_st;
		logic     adj_copy;
		logic     grid_rd_wr;
		logic     grid_wb;
		logic     grid_rd_march;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic lsq_zero;
		logic march_out;
		logic cell_hit;
		logic dist_lt;
		logic found;
	} stat_t;

endpackage

FILE: sv/grvc_if.sv
// Channel interfaces: request items, result items and register writes.
interface grvc_item_if;
	import grvc_pkg::*;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [5:0]        cell_col;
	logic [5:0]        cell_row;
	logic              cell_occupied;
	logic signed [15:0] vertex_x;
	logic signed [15:0] vertex_y;

	modport source (output valid, opcode, cell_col, cell_row, cell_occupied, vertex_x,
		vertex_y, input ready);
	modport sink (input valid, opcode, cell_col, cell_row, cell_occupied, vertex_x,
		vertex_y, output ready);
endinterface

interface grvc_result_if;
	import grvc_pkg::*;
	logic              valid;
	logic              ready;
	logic signed [15:0] adjusted_x;
	logic signed [15:0] adjusted_y;
	logic              obstacle_found;
	logic [6:0]        hit_steps;

	modport source (output valid, adjusted_x, adjusted_y, obstacle_found, hit_steps,
		input ready);
	modport sink (input valid, adjusted_x, adjusted_y, obstacle_found, hit_steps,
		output ready);
endinterface

interface grvc_cfg_if;
	import grvc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [15:0]          wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/grvc_grid.sv
// Occupancy grid memory, one row per word, with per-row valid bits for reset.
module grvc_grid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  grvc_pkg::idx_t         rd_row,
	input  logic                   wr_en,
	input  grvc_pkg::idx_t         wr_row,
	input  grvc_pkg::row_t         wr_data,
	output grvc_pkg::row_t         rd_data
);
	import grvc_pkg::*;

	row_t                 mem_q [GRID_SIDE];
	logic [GRID_SIDE-1:0] row_valid_q;
	row_t                 rd_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_row];
			end
		end
	end

	// a row never written since reset reads as free
	assign rd_data = rd_valid_q ? rd_q : '0;
endmodule

FILE: sv/grvc_datapath.sv
// Datapath: registers, multiplier, square root and divider steps, march position.
module grvc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  grvc_pkg::cmd_t                cmd,
	output grvc_pkg::stat_t               stat,
	input  logic [5:0]                    cell_col,
	input  logic [5:0]                    cell_row,
	input  logic                          cell_occupied,
	input  logic signed [15:0]            vertex_x,
	input  logic signed [15:0]            vertex_y,
	input  logic                          cfg_we,
	input  logic [grvc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_data,
	output logic                          grid_rd_en,
	output grvc_pkg::idx_t                grid_rd_row,
	output logic                          grid_wr_en,
	output grvc_pkg::idx_t                grid_wr_row,
	output grvc_pkg::row_t                grid_wr_data,
	input  grvc_pkg::row_t                grid_rd_data,
	output logic signed [15:0]            adjusted_x,
	output logic signed [15:0]            adjusted_y,
	output logic                          obstacle_found,
	output logic [6:0]                    hit_steps
);
	import grvc_pkg::*;

	logic signed [15:0]       vx_q, vy_q;
	logic [5:0]               col_q, row_q;
	logic                     occ_q;
	logic [15:0]              cell_size_q, clamp_q;
	logic [15:0]              mag_x, mag_y;
	logic [15:0]              mul_a, mul_b;
	logic [31:0]              mul_q;
	logic [31:0]              lsq_q;
	logic [RAD_W-1:0]         rad_q;
	logic [ROOT_W-1:0]        root_q;
	logic [SREM_W-1:0]        srem_q;
	logic [SREM_W:0]          rem2, trial;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W:0]           drem_q, r2;
	logic [QUO_W-1:0]         dq_q;
	logic signed [15:0]       dx_q, dy_q;
	logic signed [POS_W-1:0]  px_q, py_q;
	logic [STEP_W-1:0]        s_q;
	logic                     found_q;
	logic [15:0]              dist_q;
	logic signed [15:0]       adj_x_q, adj_y_q;
	logic signed [15:0]       quo_x, quo_y;
	logic                     x_in, y_in;
	idx_t                     cx, cy;
	logic                     wr_in_grid;
	row_t                     merged;
	logic signed [15:0]       out_x_q, out_y_q;
	logic                     out_found_q;
	logic [6:0]               out_steps_q;
	logic [6:0]               steps_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_SIZE_RST;
			clamp_q     <= CLAMP_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_CELL_SIZE) begin
				cell_size_q <= cfg_data;
			end else if (cfg_idx == REG_CLAMP) begin
				clamp_q <= cfg_data;
			end
		end
	end

	assign mag_x = vx_q[15] ? 16'(-vx_q) : 16'(vx_q);
	assign mag_y = vy_q[15] ? 16'(-vy_q) : 16'(vy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_SQX: begin
				mul_a = mag_x;
				mul_b = mag_x;
			end
			MUL_SQY: begin
				mul_a = mag_y;
				mul_b = mag_y;
			end
			MUL_DIST: begin
				mul_a = 16'(s_q);
				mul_b = cell_size_q;
			end
			MUL_VX: begin
				mul_a = mag_x;
				mul_b = dist_q;
			end
			MUL_VY: begin
				mul_a = mag_y;
				mul_b = dist_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// one-digit square root step and one-bit restoring division step
	assign rem2  = {srem_q[SREM_W-2:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign r2    = {drem_q[DEN_W-1:0], dq_q[QUO_W-1]};

	assign quo_x = vx_q[15] ? -$signed(dq_q) : $signed(dq_q);
	assign quo_y = vy_q[15] ? -$signed(dq_q) : $signed(dq_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			vx_q  <= vertex_x;
			vy_q  <= vertex_y;
			col_q <= cell_col;
			row_q <= cell_row;
			occ_q <= cell_occupied;
		end
		if (cmd.mul_sel != MUL_NONE) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.lsq_load) begin
			lsq_q <= mul_q;
		end else if (cmd.lsq_add) begin
			lsq_q <= lsq_q + mul_q;
		end
		if (cmd.sqrt_init) begin
			rad_q  <= {lsq_q, 16'b0};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rem2 >= trial) begin
				srem_q <= SREM_W'(rem2 - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= SREM_W'(rem2);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		case (cmd.div_init)
			DIV_DX: begin
				den_q  <= root_q;
				drem_q <= (DEN_W + 1)'({mag_x, 6'b0});
				dq_q   <= '0;
			end
			DIV_DY: begin
				den_q  <= root_q;
				drem_q <= (DEN_W + 1)'({mag_y, 6'b0});
				dq_q   <= '0;
			end
			DIV_SCALE: begin
				den_q  <= DEN_W'(clamp_q);
				drem_q <= (DEN_W + 1)'(mul_q[31:16]);
				dq_q   <= mul_q[15:0];
			end
			default: begin
				if (cmd.div_step) begin
					if (r2 >= {1'b0, den_q}) begin
						drem_q <= r2 - {1'b0, den_q};
						dq_q   <= {dq_q[QUO_W-2:0], 1'b1};
					end else begin
						drem_q <= r2;
						dq_q   <= {dq_q[QUO_W-2:0], 1'b0};
					end
				end
			end
		endcase
		if (cmd.dir_zero) begin
			dx_q <= DIR_ONE;
			dy_q <= '0;
		end else begin
			if (cmd.dx_st) begin
				dx_q <= quo_x;
			end
			if (cmd.dy_st) begin
				dy_q <= quo_y;
			end
		end
		if (cmd.march_init) begin
			px_q <= POS_START;
			py_q <= POS_START;
			s_q  <= '0;
		end else if (cmd.march_adv) begin
			px_q <= px_q + POS_W'(dx_q);
			py_q <= py_q + POS_W'(dy_q);
			s_q  <= s_q + 1'b1;
		end
		if (cmd.dist_st) begin
			dist_q <= mul_q[15:0];
		end
		if (cmd.adj_copy) begin
			adj_x_q <= vx_q;
			adj_y_q <= vy_q;
		end else begin
			if (cmd.adjx_st) begin
				adj_x_q <= quo_x;
			end
			if (cmd.adjy_st) begin
				adj_y_q <= quo_y;
			end
		end
		if (cmd.out_load) begin
			out_x_q     <= adj_x_q;
			out_y_q     <= adj_y_q;
			out_found_q <= found_q;
			out_steps_q <= found_q ? steps_sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.march_init) begin
			found_q <= 1'b0;
		end else if (cmd.found_set) begin
			found_q <= 1'b1;
		end
	end

	assign steps_sat = (int'(s_q) > 127) ? 7'd127 : 7'(s_q);

	// positions in (-1, 0) cell truncate to index 0
	assign x_in = (px_q > POS_NEG) && (px_q < POS_LIMIT);
	assign y_in = (py_q > POS_NEG) && (py_q < POS_LIMIT);
	assign cx   = px_q[POS_W-1] ? '0 : px_q[FRAC_W+GRID_W-1:FRAC_W];
	assign cy   = py_q[POS_W-1] ? '0 : py_q[FRAC_W+GRID_W-1:FRAC_W];

	assign wr_in_grid = (int'(col_q) < GRID_SIDE) && (int'(row_q) < GRID_SIDE);

	always_comb begin
		merged                = grid_rd_data;
		merged[idx_t'(col_q)] = occ_q;
	end

	assign grid_rd_en   = cmd.grid_rd_march || cmd.grid_rd_wr;
	assign grid_rd_row  = cmd.grid_rd_march ? cy : idx_t'(row_q);
	assign grid_wr_en   = cmd.grid_wb && wr_in_grid;
	assign grid_wr_row  = idx_t'(row_q);
	assign grid_wr_data = merged;

	assign stat.lsq_zero  = (lsq_q == '0);
	assign stat.march_out = !x_in || !y_in || (int'(s_q) > STEP_MAX);
	assign stat.cell_hit  = grid_rd_data[cx];
	assign stat.dist_lt   = (mul_q < 32'(clamp_q));
	assign stat.found     = found_q;

	assign adjusted_x     = out_x_q;
	assign adjusted_y     = out_y_q;
	assign obstacle_found = out_found_q;
	assign hit_steps      = out_steps_q;
endmodule

FILE: sv/grvc_ctrl.sv
// Controller: sequences each request through the datapath and owns both handshakes.
module grvc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_opcode,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  grvc_pkg::stat_t stat,
	output grvc_pkg::cmd_t  cmd
);
	import grvc_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last;

	assign out_free = !out_valid_q || out_ready;
	assign last     = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_ROOT_INIT: cnt_q <= CNT_W'(SQRT_ITERS - 1);
				S_DX_INIT, S_DY_INIT, S_AX_INIT, S_AY_INIT: cnt_q <= CNT_W'(DIV_ITERS - 1);
				default: cnt_q <= cnt_q - 1'b1;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_opcode == OP_WRITE) ? S_WR_RD : S_SQX;
				end
			end
			S_WR_RD:     state_d = S_WR_WB;
			S_WR_WB:     state_d = S_IDLE;
			S_SQX:       state_d = S_SQY;
			S_SQY:       state_d = S_LSQ;
			S_LSQ:       state_d = S_ROOT_INIT;
			S_ROOT_INIT: state_d = stat.lsq_zero ? S_M_INIT : S_ROOT;
			S_ROOT:      state_d = last ? S_DX_INIT : S_ROOT;
			S_DX_INIT:   state_d = S_DX;
			S_DX:        state_d = last ? S_DX_ST : S_DX;
			S_DX_ST:     state_d = S_DY_INIT;
			S_DY_INIT:   state_d = S_DY;
			S_DY:        state_d = last ? S_DY_ST : S_DY;
			S_DY_ST:     state_d = S_M_INIT;
			S_M_INIT:    state_d = S_M_ADDR;
			S_M_ADDR:    state_d = stat.march_out ? S_D_MUL : S_M_CHK;
			S_M_CHK:     state_d = stat.cell_hit ? S_D_MUL : S_M_ADDR;
			S_D_MUL:     state_d = S_D_CMP;
			S_D_CMP:     state_d = (stat.found && stat.dist_lt) ? S_AX_MUL : S_DONE;
			S_AX_MUL:    state_d = S_AX_INIT;
			S_AX_INIT:   state_d = S_AX;
			S_AX:        state_d = last ? S_AX_ST : S_AX;
			S_AX_ST:     state_d = S_AY_MUL;
			S_AY_MUL:    state_d = S_AY_INIT;
			S_AY_INIT:   state_d = S_AY;
			S_AY:        state_d = last ? S_AY_ST : S_AY;
			S_AY_ST:     state_d = S_DONE;
			S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:      cmd.load_in = in_valid;
			S_WR_RD:     cmd.grid_rd_wr = 1'b1;
			S_WR_WB:     cmd.grid_wb = 1'b1;
			S_SQX:       cmd.mul_sel = MUL_SQX;
			S_SQY: begin
				cmd.mul_sel  = MUL_SQY;
				cmd.lsq_load = 1'b1;
			end
			S_LSQ:       cmd.lsq_add = 1'b1;
			S_ROOT_INIT: begin
				cmd.dir_zero  = stat.lsq_zero;
				cmd.sqrt_init = !stat.lsq_zero;
			end
			S_ROOT:      cmd.sqrt_step = 1'b1;
			S_DX_INIT:   cmd.div_init = DIV_DX;
			S_DX:        cmd.div_step = 1'b1;
			S_DX_ST:     cmd.dx_st = 1'b1;
			S_DY_INIT:   cmd.div_init = DIV_DY;
			S_DY:        cmd.div_step = 1'b1;
			S_DY_ST:     cmd.dy_st = 1'b1;
			S_M_INIT:    cmd.march_init = 1'b1;
			S_M_ADDR:    cmd.grid_rd_march = !stat.march_out;
			S_M_CHK: begin
				cmd.found_set = stat.cell_hit;
				cmd.march_adv = !stat.cell_hit;
			end
			S_D_MUL:     cmd.mul_sel = MUL_DIST;
			S_D_CMP: begin
				cmd.dist_st  = stat.found && stat.dist_lt;
				cmd.adj_copy = !(stat.found && stat.dist_lt);
			end
			S_AX_MUL:    cmd.mul_sel = MUL_VX;
			S_AX_INIT:   cmd.div_init = DIV_SCALE;
			S_AX:        cmd.div_step = 1'b1;
			S_AX_ST:     cmd.adjx_st = 1'b1;
			S_AY_MUL:    cmd.mul_sel = MUL_VY;
			S_AY_INIT:   cmd.div_init = DIV_SCALE;
			S_AY:        cmd.div_step = 1'b1;
			S_AY_ST:     cmd.adjy_st = 1'b1;
			S_DONE:      cmd.out_load = out_free;
			default:     cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule

FILE: sv/grid_ray_vertex_clamp.sv
// Top level: occupancy grid ray march that pulls vertices in toward obstacles.
// A cell write passes through a grid read state and a write-back state before the next request is taken.
// A vertex runs the square root, two divisions and the march; a hit inside the clamp distance
// adds two scaling divisions, and a zero vertex skips the root and the divisions.
// One request is worked at a time; its result becomes valid in the same cycle that the next can be taken.
// Reset clears the grid at once through per-row valid bits and loads the register defaults.
module grid_ray_vertex_clamp (
	input logic            clk,
	input logic            arst_n,
	grvc_item_if.sink      item,
	grvc_result_if.source  result,
	grvc_cfg_if.sink       cfg
);
	import grvc_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  grid_rd_en, grid_wr_en;
	idx_t  grid_rd_row, grid_wr_row;
	row_t  grid_wr_data, grid_rd_data;

	assign cfg.ready = 1'b1;

	grvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_opcode (item.opcode),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	grvc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cell_col       (item.cell_col),
		.cell_row       (item.cell_row),
		.cell_occupied  (item.cell_occupied),
		.vertex_x       (item.vertex_x),
		.vertex_y       (item.vertex_y),
		.cfg_we         (cfg.valid),
		.cfg_idx        (cfg.reg_index),
		.cfg_data       (cfg.wdata),
		.grid_rd_en     (grid_rd_en),
		.grid_rd_row    (grid_rd_row),
		.grid_wr_en     (grid_wr_en),
		.grid_wr_row    (grid_wr_row),
		.grid_wr_data   (grid_wr_data),
		.grid_rd_data   (grid_rd_data),
		.adjusted_x     (result.adjusted_x),
		.adjusted_y     (result.adjusted_y),
		.obstacle_found (result.obstacle_found),
		.hit_steps      (result.hit_steps)
	);

	grvc_grid u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (grid_rd_en),
		.rd_row  (grid_rd_row),
		.wr_en   (grid_wr_en),
		.wr_row  (grid_wr_row),
		.wr_data (grid_wr_data),
		.rd_data (grid_rd_data)
	);
endmodule

FILE: sv/grvc_checker.sv
// Port-level checks on the top level, attached by bind.
module grvc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              item_opcode,
	input logic              result_valid,
	input logic              result_ready,
	input logic signed [15:0] result_adjusted_x,
	input logic signed [15:0] result_adjusted_y,
	input logic              result_obstacle_found,
	input logic [6:0]        result_hit_steps
);
	import grvc_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_adjusted_x)
		&& $stable(result_adjusted_y) && $stable(result_hit_steps))
	else $error("stalled result changed");

	a_no_hit_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_obstacle_found |-> result_hit_steps == 7'd0)
	else $error("hit steps without obstacle");

	// a cell write never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_opcode == OP_WRITE |=> !$rose(result_valid))
	else $error("result after cell write");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
	else $error("request taken while busy");
endmodule

bind grid_ray_vertex_clamp grvc_checker u_grvc_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.item_valid            (item.valid),
	.item_ready            (item.ready),
	.item_opcode           (item.opcode),
	.result_valid          (result.valid),
	.result_ready          (result.ready),
	.result_adjusted_x     (result.adjusted_x),
	.result_adjusted_y     (result.adjusted_y),
	.result_obstacle_found (result.obstacle_found),
	.result_hit_steps      (result.hit_steps)
);

FILE: tb/grvc_tb_if.sv
// Testbench request and result types of the grid ray vertex clamp.
package grvc_tb_types;
	import grvc_pkg::*;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  col;
		logic [5:0]  row;
		logic        occ;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} request_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic        found;
		logic [6:0]  steps;
	} clamp_result_t;
endpackage

FILE: tb/grid_ray_vertex_clamp_tb.sv
// Self-checking testbench of the grid ray vertex clamp: directed table, then random requests.
module grid_ray_vertex_clamp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import grvc_pkg::*;
	import grvc_tb_types::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	grvc_item_if   item();
	grvc_result_if result();
	grvc_cfg_if    cfg();

	grid_ray_vertex_clamp dut (.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.cfg(cfg));

	// model state
	logic        occ_grid [GRID_SIDE*GRID_SIDE];
	logic [15:0] cell_size_q;
	logic [15:0] clamp_q;
	clamp_result_t pending_q[$];

	int errors = 0;
	longint cycles = 0;
	int send_idle = 20;
	int recv_idle = 62;
	bit recv_hold = 1'b0;

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint quot_toward_zero(longint num, longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = m / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic longint cell_of(longint p);
		if (p < 0) return -((-p) >>> 14);
		return p >>> 14;
	endfunction

	function automatic clamp_result_t march_vertex(logic signed [15:0] vx16,
			logic signed [15:0] vy16);
		clamp_result_t r;
		longint vx, vy, dx, dy, cx, cy, ax, ay, span;
		longint unsigned lsq, len;
		int s, steps;
		bit hit;
		vx = vx16;
		vy = vy16;
		dx = 16384;
		dy = 0;
		hit = 0;
		steps = 0;
		lsq = vx * vx + vy * vy;
		if (lsq != 0) begin
			len = int_root(lsq << 16);
			dx = quot_toward_zero(vx * (64'sd1 << 22), len);
			dy = quot_toward_zero(vy * (64'sd1 << 22), len);
		end
		for (s = 0; s <= 4 * GRID_SIDE; s++) begin
			cx = cell_of((GRID_SIDE / 2) * 16384 + dx * s);
			cy = cell_of((GRID_SIDE / 2) * 16384 + dy * s);
			if (cx < 0 || cx >= GRID_SIDE || cy < 0 || cy >= GRID_SIDE) break;
			if (occ_grid[cy * GRID_SIDE + cx]) begin
				hit = 1;
				steps = s;
				break;
			end
		end
		ax = vx;
		ay = vy;
		if (hit) begin
			span = steps * longint'(cell_size_q);
			if (span < clamp_q) begin
				ax = quot_toward_zero(vx * span, clamp_q);
				ay = quot_toward_zero(vy * span, clamp_q);
			end
		end
		r.ax = ax[15:0];
		r.ay = ay[15:0];
		r.found = hit;
		r.steps = hit ? ((steps > 127) ? 7'd127 : 7'(steps)) : 7'd0;
		return r;
	endfunction

	function automatic void apply_request(request_t q);
		if (q.opcode == OP_WRITE) occ_grid[q.row * GRID_SIDE + q.col] = q.occ;
		else pending_q.insert(pending_q.size(), march_vertex(q.vx, q.vy));
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	initial begin
		item.valid = 1'b0;
		item.opcode = OP_WRITE;
		item.cell_col = '0;
		item.cell_row = '0;
		item.cell_occupied = 1'b0;
		item.vertex_x = '0;
		item.vertex_y = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.reg_index = REG_CELL_SIZE;
		cfg.wdata = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, with a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n || recv_hold) result.ready <= 1'b0;
		else result.ready <= ($urandom_range(99) >= recv_idle);
	end

	// check results
	always @(posedge clk) begin
		clamp_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_q.pop_front();
				if (result.adjusted_x !== want.ax)
					report_mismatch("adjusted_x", result.adjusted_x, want.ax);
				if (result.adjusted_y !== want.ay)
					report_mismatch("adjusted_y", result.adjusted_y, want.ay);
				if (result.obstacle_found !== want.found)
					report_mismatch("obstacle_found", result.obstacle_found, want.found);
				if (result.hit_steps !== want.steps)
					report_mismatch("hit_steps", result.hit_steps, want.steps);
			end
		end
	end

	// valid stays up after acceptance until the next request or a drain replaces it
	task automatic send_request(request_t q);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.opcode <= q.opcode;
		item.cell_col <= q.col;
		item.cell_row <= q.row;
		item.cell_occupied <= q.occ;
		item.vertex_x <= q.vx;
		item.vertex_y <= q.vy;
		do @(posedge clk); while (!item.ready);
		apply_request(q);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		item.valid <= 1'b0;
		while (pending_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// a cell write may still be in flight
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_CELL_SIZE) cell_size_q = v;
		else if (idx == REG_CLAMP) clamp_q = v;
		@(posedge clk);
	endtask

	function automatic request_t cell_write(int c, int r, bit o);
		request_t q;
		q = '0;
		q.opcode = OP_WRITE;
		q.col = 6'(c);
		q.row = 6'(r);
		q.occ = o;
		return q;
	endfunction

	function automatic request_t vertex_req(int x, int y);
		request_t q;
		q = '0;
		q.opcode = OP_VERTEX;
		q.col = 6'($urandom);
		q.row = 6'($urandom);
		q.occ = 1'($urandom);
		q.vx = 16'(x);
		q.vy = 16'(y);
		return q;
	endfunction

	function automatic request_t random_request(bit mostly_vertex);
		request_t q;
		int roll;
		q.col = 6'($urandom);
		q.row = 6'($urandom);
		q.occ = ($urandom_range(99) < 30);
		q.vx = 16'($urandom);
		q.vy = 16'($urandom);
		roll = $urandom_range(9);
		if (roll == 0) begin
			q.vx = 16'($urandom_range(7)) - 16'sd4;
			q.vy = 16'($urandom_range(7)) - 16'sd4;
		end else if (roll == 1) begin
			q.vx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		end
		q.opcode = mostly_vertex ? ($urandom_range(99) < 60) : ($urandom_range(99) < 30);
		return q;
	endfunction

	typedef struct {
		request_t req;
		bit       has_want;
		clamp_result_t want;
	} table_row_t;

	initial begin
		table_row_t rows[$];
		table_row_t tr;
		clamp_result_t got_want;
		int i, phase;
		for (i = 0; i < GRID_SIDE * GRID_SIDE; i++) occ_grid[i] = 1'b0;
		cell_size_q = CELL_SIZE_RST;
		clamp_q = CLAMP_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty grid leaves vertices unchanged, extremes, hits
		tr.has_want = 1;
		tr.req = vertex_req(0, 0);
		tr.want = '{ax: 16'sd0, ay: 16'sd0, found: 1'b0, steps: 7'd0};
		rows.insert(rows.size(), tr);
		tr.req = vertex_req(32767, -32768);
		tr.want = '{ax: 16'sh7fff, ay: 16'sh8000, found: 1'b0, steps: 7'd0};
		rows.insert(rows.size(), tr);
		tr.req = vertex_req(-32768, 32767);
		tr.want = '{ax: 16'sh8000, ay: 16'sh7fff, found: 1'b0, steps: 7'd0};
		rows.insert(rows.size(), tr);
		tr.has_want = 0;
		rows.insert(rows.size(), '{cell_write(63, 63, 1), 0, '0});
		rows.insert(rows.size(), '{cell_write(0, 0, 1), 0, '0});
		rows.insert(rows.size(), '{cell_write(40, 32, 1), 0, '0});
		rows.insert(rows.size(), '{vertex_req(256, 0), 0, '0});
		rows.insert(rows.size(), '{vertex_req(0, 0), 0, '0});
		rows.insert(rows.size(), '{vertex_req(-1, -1), 0, '0});
		rows.insert(rows.size(), '{vertex_req(1000, 1000), 0, '0});
		rows.insert(rows.size(), '{vertex_req(-32768, -32768), 0, '0});
		rows.insert(rows.size(), '{cell_write(32, 32, 1), 0, '0});
		tr.has_want = 1;
		tr.req = vertex_req(1234, -567);
		tr.want = '{ax: 16'sd0, ay: 16'sd0, found: 1'b1, steps: 7'd0};
		rows.insert(rows.size(), tr);
		rows.insert(rows.size(), '{cell_write(32, 32, 0), 0, '0});
		rows.insert(rows.size(), '{vertex_req(5, 0), 0, '0});
		rows.insert(rows.size(), '{cell_write(40, 32, 0), 0, '0});
		rows.insert(rows.size(), '{vertex_req(0, 300), 0, '0});
		foreach (rows[k]) begin
			send_request(rows[k].req);
			if (rows[k].has_want) begin
				got_want = pending_q[$];
				if (got_want !== rows[k].want)
					report_mismatch("table row", k, k);
			end
		end
		drain_results();

		// random phases under several register settings and idling patterns
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
			0: begin
				write_register(REG_CELL_SIZE, 16'd1);
				write_register(REG_CLAMP, 16'd65535);
			end
			1: begin
				write_register(REG_CELL_SIZE, 16'd65535);
				write_register(REG_CLAMP, 16'd1);
			end
			2: begin
				send_idle = 62;
				recv_idle = 20;
				write_register(REG_CELL_SIZE, 16'($urandom_range(1, 400)));
				write_register(REG_CLAMP, 16'($urandom_range(1, 8000)));
			end
			3: begin
				write_register(REG_CELL_SIZE, CELL_SIZE_RST);
				write_register(REG_CLAMP, CLAMP_RST);
			end
			4: begin
				send_idle = 0;
				recv_idle = 0;
				write_register(REG_CELL_SIZE, 16'd200);
				write_register(REG_CLAMP, 16'd3000);
			end
			default: begin
				write_register(REG_CELL_SIZE, 16'($urandom));
				write_register(REG_CLAMP, 16'($urandom_range(1, 65535)));
			end
			endcase
			// random obstacle writes, occupied or free, on top of the current field
			for (i = 0; i < 40; i++)
				send_request(cell_write($urandom_range(63), $urandom_range(63),
					$urandom_range(1)));
			for (i = 0; i < 190; i++) begin
				if (phase == 4 && i == 20) begin
					fork
						begin
							recv_hold = 1'b1;
							repeat (600) @(posedge clk);
							recv_hold = 1'b0;
						end
					join_none
				end
				send_request(random_request(1'b1));
			end
			drain_results();
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
